>>> hw/rtl/csatag_pkg.sv
// Shared types and codes for the coherent set-associative cache tag block.
// No dependencies; csatag_update and the top-level module import this package.

package csatag_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 4;
   localparam int ADDR_PORT_WIDTH = 32;
   localparam int SET_OUT_WIDTH   = 6;
   localparam int WAY_OUT_WIDTH   = 2;
   localparam int SET_RAW_WIDTH   = 7;
   localparam int SET_RAW_COUNT   = 128;

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_STORE    = 2'd1,
      OP_SNOOP_RD = 2'd2,
      OP_SNOOP_WR = 2'd3
   } csatag_op_type;

   typedef enum logic [1:0] {
      ST_INV = 2'd0,
      ST_VAL = 2'd1,
      ST_SHR = 2'd2,
      ST_MOD = 2'd3
   } csatag_state_type;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_VI   = 2'd1,
      MODE_MSI  = 2'd2
   } csatag_mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PROTOCOL_MODE = 3'd0,
      CSR_VICTIM_INVAL  = 3'd1,
      CSR_OFFSET_BITS   = 3'd2,
      CSR_INDEX_BITS    = 3'd3,
      CSR_WAYS_USED     = 3'd4
   } csatag_csr_type;

   typedef struct packed {
      logic [1:0] protocol_mode;
      logic       victim_on_invalidate;
      logic [3:0] offset_bits;
      logic [2:0] index_bits;
      logic [2:0] ways_used;
   } csatag_cfg_type;

   typedef struct packed {
      logic                     hit;
      logic                     writeback;
      logic                     store_upgrade;
      logic [WAY_OUT_WIDTH-1:0] way_used;
   } csatag_result_type;

endpackage

>>> hw/rtl/csatag_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the per-set tag and state rows.

module csatag_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read and a write to the same address in one cycle return the old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/csatag_update.sv
// Lookup and state update for one set row: way match, coherence action, victim pointer.
// Depends on csatag_pkg for op, state and mode codes and the config and result structs.

module csatag_update #(
   parameter int WAYS  = 4,
   parameter int TAG_W = 32,
   parameter int WAY_W = 2
) (
   input  csatag_pkg::csatag_cfg_type              cfg,
   input  csatag_pkg::csatag_op_type               op,
   input  logic [TAG_W-1:0]                        tag,
   input  logic [WAYS-1:0][TAG_W-1:0]              tags_cur,
   input  logic [WAYS-1:0][1:0]                    states_cur,
   input  logic [WAYS-1:0]                         dirty_cur,
   input  logic [WAY_W-1:0]                        ptr_cur,
   output logic [WAYS-1:0][TAG_W-1:0]              tags_new,
   output logic [WAYS-1:0][1:0]                    states_new,
   output logic [WAYS-1:0]                         dirty_new,
   output logic [WAY_W-1:0]                        ptr_new,
   output csatag_pkg::csatag_result_type           result
);

   import csatag_pkg::*;

   localparam int PTR_TABLE_DEPTH = (2 ** WAY_W) * 8;

   // Stale pointer folded into the active ways: indexed by {pointer, ways}.
   logic [WAY_W-1:0] ptr_mod_table [PTR_TABLE_DEPTH];

   for (genvar g = 0; g < PTR_TABLE_DEPTH; g++) begin : g_ptr_mod
      localparam int PTR_VAL  = g / 8;
      localparam int WAYS_VAL = g % 8;
      localparam int FOLDED   = (WAYS_VAL == 0) ? 0
                              : PTR_VAL % ((WAYS_VAL == 0) ? 1 : WAYS_VAL);
      assign ptr_mod_table[g] = WAY_W'(FOLDED);
   end

   logic [2:0]       ways_eff;
   logic             mode_msi;
   logic             mode_vi;
   logic             is_local;
   logic             is_store;
   logic             found;
   logic [WAY_W-1:0] way;
   logic [WAY_W:0]   way_plus;
   logic [WAY_W-1:0] way_next;
   logic             ways_gt1;
   logic             hit;
   logic             wb;
   logic             upg;
   logic [1:0]       st_w;
   logic             dirty_w;

   always_comb begin
      ways_eff = cfg.ways_used;
      if (cfg.ways_used == 3'd0) begin
         ways_eff = 3'd1;
      end else if (int'(cfg.ways_used) > WAYS) begin
         ways_eff = 3'(WAYS);
      end
   end

   assign mode_msi = (cfg.protocol_mode == MODE_MSI);
   assign mode_vi  = (cfg.protocol_mode == MODE_VI);
   assign is_local = (op == OP_LOAD) || (op == OP_STORE);
   assign is_store = (op == OP_STORE);
   assign ways_gt1 = (ways_eff > 3'd1);

   // Parallel tag compare; the lowest matching active way wins.
   always_comb begin
      found = 1'b0;
      way   = ptr_mod_table[{ptr_cur, ways_eff}];
      for (int i = 0; i < WAYS; i++) begin
         if (!found && (i < int'(ways_eff)) && (tags_cur[i] == tag) &&
             (mode_msi ? (states_cur[i] != ST_INV) : (states_cur[i] == ST_VAL))) begin
            found = 1'b1;
            way   = WAY_W'(i);
         end
      end
   end

   assign way_plus = {1'b0, way} + (WAY_W+1)'(1);
   assign way_next = (way_plus == (WAY_W+1)'(ways_eff)) ? WAY_W'(0) : way_plus[WAY_W-1:0];
   assign st_w     = states_cur[way];
   assign dirty_w  = dirty_cur[way];

   always_comb begin
      tags_new   = tags_cur;
      states_new = states_cur;
      dirty_new  = dirty_cur;
      ptr_new    = ptr_cur;
      hit        = found;
      wb         = 1'b0;
      upg        = 1'b0;
      if (mode_msi) begin
         if (!found) begin
            if (is_local) begin
               wb              = dirty_w && (st_w != ST_INV);
               tags_new[way]   = tag;
               states_new[way] = is_store ? ST_MOD : ST_SHR;
               dirty_new[way]  = is_store;
               if (ways_gt1) begin
                  ptr_new = way_next;
               end
            end
         end else if (is_local) begin
            ptr_new = way_next;
            if (is_store) begin
               if (st_w == ST_SHR) begin
                  states_new[way] = ST_MOD;
                  hit             = 1'b0;
                  upg             = 1'b1;
               end
               dirty_new[way] = 1'b1;
            end
         end else if (op == OP_SNOOP_RD) begin
            if (st_w == ST_MOD) begin
               states_new[way] = ST_SHR;
               dirty_new[way]  = 1'b0;
               wb              = 1'b1;
            end
         end else begin
            states_new[way] = ST_INV;
            wb              = dirty_w;
            dirty_new[way]  = 1'b0;
            if (cfg.victim_on_invalidate) begin
               ptr_new = way;
            end
         end
      end else begin
         if (!found) begin
            if (is_local) begin
               wb              = dirty_w;
               tags_new[way]   = tag;
               states_new[way] = ST_VAL;
               dirty_new[way]  = is_store;
            end
         end else if (is_local) begin
            states_new[way] = ST_VAL;
            if (is_store) begin
               dirty_new[way] = 1'b1;
            end
         end else if (mode_vi) begin
            wb              = dirty_w && (st_w == ST_VAL);
            dirty_new[way]  = 1'b0;
            states_new[way] = ST_INV;
         end
         if (ways_gt1) begin
            ptr_new = way_next;
         end
      end
   end

   always_comb begin
      result.hit           = hit;
      result.writeback     = wb;
      result.store_upgrade = upg;
      result.way_used      = WAY_OUT_WIDTH'(way);
   end

endmodule

>>> hw/rtl/coherent_set_assoc_cache_tags.sv
// Coherent set-associative cache tag and state array (none, VI or MSI coherence).
// A request is registered into stage one while its set row is read, then into the response register.
// Throughput: one request per cycle while the response is not stalled; the set row is read and written
// back once per request. Reset: synchronous; config returns to defaults and a clearing pass writes
// every set row to zero, during which no request is accepted.
// Depends on csatag_pkg, csatag_ram and csatag_update.

module coherent_set_assoc_cache_tags #(
   parameter int SETS       = 64,
   parameter int WAYS       = 4,
   parameter int ADDR_WIDTH = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // Request channel
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic [1:0]                                  req_op,
   input  logic [csatag_pkg::ADDR_PORT_WIDTH-1:0]      req_addr,
   // Response channel
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic                                        rsp_hit,
   output logic                                        rsp_writeback,
   output logic                                        rsp_store_upgrade,
   output logic [csatag_pkg::SET_OUT_WIDTH-1:0]        rsp_set_index,
   output logic [csatag_pkg::WAY_OUT_WIDTH-1:0]        rsp_way_used,
   // Configuration write channel
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [csatag_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [csatag_pkg::CSR_DATA_WIDTH-1:0]       csr_wdata
);

   import csatag_pkg::*;

   // The tag is the address above the offset and index fields, so it never needs
   // more bits than the address space (capped at the width of the address port).
   localparam int TAG_W = (ADDR_WIDTH < ADDR_PORT_WIDTH) ? ADDR_WIDTH : ADDR_PORT_WIDTH;
   localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W = WAY_W + WAYS * (TAG_W + 3);

   // ------------------------------------------------------------------
   // Configuration registers. The port is always ready; writes to an
   // index past the last register are dropped.
   // ------------------------------------------------------------------
   csatag_cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.protocol_mode        <= MODE_NONE;
         cfg_ff.victim_on_invalidate <= 1'b0;
         cfg_ff.offset_bits          <= 4'd4;
         cfg_ff.index_bits           <= 3'd6;
         cfg_ff.ways_used            <= 3'd4;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PROTOCOL_MODE: cfg_ff.protocol_mode        <= csr_wdata[1:0];
            CSR_VICTIM_INVAL:  cfg_ff.victim_on_invalidate <= csr_wdata[0];
            CSR_OFFSET_BITS:   cfg_ff.offset_bits          <= csr_wdata[3:0];
            CSR_INDEX_BITS:    cfg_ff.index_bits           <= csr_wdata[2:0];
            CSR_WAYS_USED:     cfg_ff.ways_used            <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Clearing pass. After reset every set row is written to zero, which
   // is the invalid state with clean lines, zero tags and pointer zero.
   // ------------------------------------------------------------------
   logic             clearing_ff;
   logic             clearing_in;
   logic [SET_W-1:0] clear_cnt_ff;
   logic [SET_W-1:0] clear_cnt_in;

   always_comb begin
      clearing_in  = clearing_ff;
      clear_cnt_in = clear_cnt_ff;
      if (clearing_ff) begin
         clear_cnt_in = clear_cnt_ff + SET_W'(1);
         if (clear_cnt_ff == SET_W'(SETS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_cnt_ff <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // ------------------------------------------------------------------
   // Request side: address split into set and tag. The raw index field is
   // at most seven bits wide, so the fold into SETS sets is a small table.
   // ------------------------------------------------------------------
   logic [SET_W-1:0]         set_mod_table [SET_RAW_COUNT];
   logic [TAG_W-1:0]         addr_low;
   logic [SET_RAW_WIDTH-1:0] set_raw;
   logic [SET_RAW_WIDTH-1:0] index_mask;
   logic [4:0]               tag_shift;
   logic [SET_W-1:0]         req_set;
   logic [TAG_W-1:0]         req_tag;

   for (genvar g = 0; g < SET_RAW_COUNT; g++) begin : g_set_mod
      localparam int SET_VAL = g % SETS;
      assign set_mod_table[g] = SET_W'(SET_VAL);
   end

   assign addr_low   = req_addr[TAG_W-1:0];
   assign index_mask = SET_RAW_WIDTH'((8'd1 << cfg_ff.index_bits) - 8'd1);
   assign set_raw    = SET_RAW_WIDTH'(addr_low >> cfg_ff.offset_bits) & index_mask;
   assign tag_shift  = 5'(cfg_ff.offset_bits) + 5'(cfg_ff.index_bits);
   assign req_set    = set_mod_table[set_raw];
   assign req_tag    = addr_low >> tag_shift;

   // ------------------------------------------------------------------
   // Handshake. Stage one holds the accepted request while the set row is
   // read; it moves into the response register whenever that register is
   // empty or being drained in the same cycle.
   // ------------------------------------------------------------------
   logic             s1_valid_ff;
   logic             s1_valid_in;
   csatag_op_type    s1_op_ff;
   logic [SET_W-1:0] s1_set_ff;
   logic [TAG_W-1:0] s1_tag_ff;
   logic             s1_advance;
   logic             req_accept;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_load;

   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = clearing_ff || (s1_valid_ff && !s1_advance);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = s1_valid_ff && s1_advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = s1_advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff  <= csatag_op_type'(req_op);
         s1_set_ff <= req_set;
         s1_tag_ff <= req_tag;
      end
   end

   // ------------------------------------------------------------------
   // Set row storage. A row holds the victim pointer and, for each way,
   // the dirty bit, the line state and the tag. The row is read when a
   // request is accepted and written back when it leaves stage one.
   // ------------------------------------------------------------------
   logic             ram_wr_en;
   logic [SET_W-1:0] ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;
   logic [ROW_W-1:0] ram_rd_data;
   logic [ROW_W-1:0] row_cur;
   logic [ROW_W-1:0] row_new;

   assign ram_wr_en   = clearing_ff || rsp_load;
   assign ram_wr_addr = clearing_ff ? clear_cnt_ff : s1_set_ff;
   assign ram_wr_data = clearing_ff ? '0 : row_new;

   csatag_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_set),
      .rd_data (ram_rd_data)
   );

   // The previous request writes its row on the same edge at which the next
   // one reads, and the RAM returns the old row then. Keeping a copy of the
   // last row written covers that case; back-to-back requests to one set
   // therefore see each other's updates.
   logic             fwd_valid_ff;
   logic [SET_W-1:0] fwd_set_ff;
   logic [ROW_W-1:0] fwd_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         fwd_set_ff <= s1_set_ff;
         fwd_row_ff <= row_new;
      end
   end

   assign row_cur = (fwd_valid_ff && (fwd_set_ff == s1_set_ff)) ? fwd_row_ff : ram_rd_data;

   logic [WAYS-1:0][TAG_W-1:0] cur_tags;
   logic [WAYS-1:0][1:0]       cur_states;
   logic [WAYS-1:0]            cur_dirty;
   logic [WAY_W-1:0]           cur_ptr;
   logic [WAYS-1:0][TAG_W-1:0] new_tags;
   logic [WAYS-1:0][1:0]       new_states;
   logic [WAYS-1:0]            new_dirty;
   logic [WAY_W-1:0]           new_ptr;
   csatag_result_type          s1_result;

   assign {cur_ptr, cur_dirty, cur_states, cur_tags} = row_cur;
   assign row_new = {new_ptr, new_dirty, new_states, new_tags};

   csatag_update #(
      .WAYS  (WAYS),
      .TAG_W (TAG_W),
      .WAY_W (WAY_W)
   ) u_update (
      .cfg        (cfg_ff),
      .op         (s1_op_ff),
      .tag        (s1_tag_ff),
      .tags_cur   (cur_tags),
      .states_cur (cur_states),
      .dirty_cur  (cur_dirty),
      .ptr_cur    (cur_ptr),
      .tags_new   (new_tags),
      .states_new (new_states),
      .dirty_new  (new_dirty),
      .ptr_new    (new_ptr),
      .result     (s1_result)
   );

   // ------------------------------------------------------------------
   // Response register.
   // ------------------------------------------------------------------
   csatag_result_type          rsp_result_ff;
   logic [SET_OUT_WIDTH-1:0]   rsp_set_ff;

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_result_ff <= s1_result;
         rsp_set_ff    <= SET_OUT_WIDTH'(s1_set_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_result_ff.hit;
   assign rsp_writeback     = rsp_result_ff.writeback;
   assign rsp_store_upgrade = rsp_result_ff.store_upgrade;
   assign rsp_set_index     = rsp_set_ff;
   assign rsp_way_used      = rsp_result_ff.way_used;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // Nothing may be in flight while the clearing pass owns the RAM write port.
   a_idle_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> (!s1_valid_ff && !rsp_valid_ff))
      else $error("request in flight during clearing pass");

   // A new response only ever comes out of stage one.
   a_rsp_from_stage1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("response appeared without a request in stage one");

   // An upgrade miss always clears the hit flag.
   a_upgrade_not_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_result_ff.store_upgrade && rsp_result_ff.hit))
      else $error("upgrade miss reported together with hit");

   // Upgrades only exist under MSI.
   a_upgrade_msi_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && s1_result.store_upgrade) |-> (cfg_ff.protocol_mode == MODE_MSI))
      else $error("upgrade miss outside MSI mode");

endmodule
